/* rtl/core/btmx_pkg.sv */
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared types and codes for the binary trie max-xor multiset block.
// ----------------------------------------------------------------------------
package btmx_pkg;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key;
    logic [19:0] entry_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] best_id;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WALK,
    S_INS_CHK,
    S_N_ALLOC,
    S_N_FREE,
    S_N_LINK,
    S_E_ALLOC,
    S_E_FREE,
    S_E_WRITE,
    S_E_TAIL,
    S_L_WRITE,
    S_DEL_HEAD,
    S_PR_CLR,
    S_PR_STEP,
    S_PR_RD,
    S_PR_FREE,
    S_E_RELEASE,
    S_Q_ID,
    S_DONE
  } state_e;

endpackage

/* rtl/core/binary_trie_max_xor_multiset.sv */
// ----------------------------------------------------------------------------
// binary_trie_max_xor_multiset
// Multiset of keys in a binary trie with per-key id FIFOs; insert, delete
// oldest, and max-xor query, one item at a time.
// ----------------------------------------------------------------------------
// One item is in work at a time; each takes a walk of up to KEY_BITS + 1
// dependent node reads, root included, one per cycle through the node
// memory's read port. An insert also creates the trie nodes that the key
// lacks, and a delete prunes the nodes that lead only to the key when its
// last id goes. The next item is taken while a result waits in the output
// register. No clearing pass runs after reset: only the root is read
// before being written, and it reads as empty until then.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_multiset
  import btmx_pkg::*;
#(
  parameter int KEY_BITS    = 64,
  parameter int NODE_COUNT  = 65536,
  parameter int ENTRY_COUNT = 65536,
  parameter int ID_BITS     = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int NAW = $clog2(NODE_COUNT);
  localparam int EAW = $clog2(ENTRY_COUNT);
  localparam int LW  = (NAW > EAW) ? NAW : EAW;
  localparam int NWW = 2 * LW;
  localparam int EWW = ID_BITS + EAW;
  localparam int NCW = $clog2(NODE_COUNT + 1);
  localparam int ECW = $clog2(ENTRY_COUNT + 1);
  localparam int DW  = $clog2(KEY_BITS + 1);
  localparam int KBW = $clog2(KEY_BITS);

  function automatic logic [NAW-1:0] nidx(input logic [LW-1:0] v);
    return (32'(v) < NODE_COUNT) ? v[NAW-1:0] : '0;
  endfunction

  function automatic logic [EAW-1:0] eidx(input logic [LW-1:0] v);
    return (32'(v) < ENTRY_COUNT) ? v[EAW-1:0] : '0;
  endfunction

  state_e state_q, state_d;

  // control registers
  logic            out_valid_q, out_valid_d;
  logic [NAW-1:0]  node_fh_q, node_fh_d;
  logic [EAW-1:0]  ent_fh_q, ent_fh_d;
  logic [NCW-1:0]  node_bump_q, node_bump_d;
  logic [ECW-1:0]  ent_bump_q, ent_bump_d;
  logic [NCW-1:0]  nodes_used_q, nodes_used_d;
  logic [ECW-1:0]  ents_used_q, ents_used_d;

  // payload registers
  out_item_t       out_item_q, out_item_d;
  logic [1:0]      req_q, req_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [ID_BITS-1:0]  id_q, id_d;
  logic [ID_BITS-1:0]  val_q, val_d;
  logic [1:0]      status_q, status_d;
  logic [NAW-1:0]  cur_q, cur_d;
  logic [NAW-1:0]  nxt_q, nxt_d;
  logic [DW-1:0]   depth_q, depth_d;
  logic [DW-1:0]   missing_q, missing_d;
  logic [NAW-1:0]  parent_q, parent_d;
  logic [NWW-1:0]  pword_q, pword_d;
  logic [NAW-1:0]  new_q, new_d;
  logic [NAW-1:0]  leaf_q, leaf_d;
  logic [NWW-1:0]  lword_q, lword_d;
  logic [EAW-1:0]  ent_q, ent_d;
  logic [EAW-1:0]  head_q, head_d;
  logic [NAW-1:0]  br_node_q, br_node_d;
  logic [NWW-1:0]  br_word_q, br_word_d;
  logic [DW-1:0]   br_depth_q, br_depth_d;

  // memory ports
  logic            n_rd_en, n_wr_en;
  logic [NAW-1:0]  n_rd_addr, n_wr_addr;
  logic [NWW-1:0]  n_rd_data, n_wr_data;
  logic            e_rd_en, e_wr_en;
  logic [EAW-1:0]  e_rd_addr, e_wr_addr;
  logic [EWW-1:0]  e_rd_data, e_wr_data;

  btmx_node_mem #(.DEPTH(NODE_COUNT), .AW(NAW), .WIDTH(NWW)) u_node_mem (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .rd_en_i            (n_rd_en),
    .rd_addr_i          (n_rd_addr),
    .rd_data_o          (n_rd_data),
    .wr_en_i            (n_wr_en),
    .wr_addr_i          (n_wr_addr),
    .wr_data_o_unused_i (n_wr_data)
  );

  btmx_entry_mem #(.DEPTH(ENTRY_COUNT), .AW(EAW), .WIDTH(EWW)) u_entry_mem (
    .clk_i     (clk_i),
    .rd_en_i   (e_rd_en),
    .rd_addr_i (e_rd_addr),
    .rd_data_o (e_rd_data),
    .wr_en_i   (e_wr_en),
    .wr_addr_i (e_wr_addr),
    .wr_data_i (e_wr_data)
  );

  // walk helpers
  logic            at_leaf, depth0, root_empty, bit_cur, full;
  logic [KBW-1:0]  kidx;
  logic [LW-1:0]   link_b, link_nb, link0, link1;
  logic [NAW-1:0]  child, q_next, bump_node;
  logic [ID_BITS-1:0] e_id;
  logic [EAW-1:0]  e_next;

  assign at_leaf    = (depth_q == DW'(KEY_BITS));
  assign depth0     = (depth_q == '0);
  assign kidx       = KBW'(KEY_BITS - 1) - depth_q[KBW-1:0];
  assign bit_cur    = at_leaf ? 1'b0 : key_q[kidx];
  assign link0      = n_rd_data[LW-1:0];
  assign link1      = n_rd_data[NWW-1:LW];
  assign link_b     = bit_cur ? link1 : link0;
  assign link_nb    = bit_cur ? link0 : link1;
  assign root_empty = (n_rd_data == '0);
  assign child      = nidx(link_b);
  assign q_next     = nidx((link_nb != '0) ? link_nb : link_b);
  assign bump_node  = (32'(node_bump_q) < NODE_COUNT) ? node_bump_q[NAW-1:0] : '0;
  assign e_id       = e_rd_data[EWW-1:EAW];
  assign e_next     = e_rd_data[EAW-1:0];
  assign full       = (32'(missing_q) > NODE_COUNT - 32'(nodes_used_q)) ||
                      (32'(ents_used_q) >= ENTRY_COUNT - 1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_WALK;
      S_WALK: begin
        case (req_q)
          REQ_INSERT: begin
            if (at_leaf || child == '0) state_d = S_INS_CHK;
          end
          REQ_DELETE: begin
            if (at_leaf) state_d = S_DEL_HEAD;
            else if ((depth0 && root_empty) || child == '0) state_d = S_DONE;
          end
          REQ_QUERY: begin
            if (at_leaf) state_d = S_Q_ID;
            else if (depth0 && root_empty) state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_INS_CHK: begin
        if (full) state_d = S_DONE;
        else if (missing_q == '0) state_d = S_E_ALLOC;
        else state_d = S_N_ALLOC;
      end
      S_N_ALLOC: state_d = (node_fh_q != '0) ? S_N_FREE : S_N_LINK;
      S_N_FREE:  state_d = S_N_LINK;
      S_N_LINK:  state_d = (depth_q + 1'b1 == DW'(KEY_BITS)) ? S_E_ALLOC : S_N_ALLOC;
      S_E_ALLOC: state_d = (ent_fh_q != '0) ? S_E_FREE : S_E_WRITE;
      S_E_FREE:  state_d = S_E_WRITE;
      S_E_WRITE: state_d = (lword_q[LW-1:0] != '0) ? S_E_TAIL : S_L_WRITE;
      S_E_TAIL:  state_d = S_L_WRITE;
      S_L_WRITE: state_d = S_DONE;
      S_DEL_HEAD: begin
        state_d = (LW'(head_q) != lword_q[NWW-1:LW]) ? S_E_RELEASE : S_PR_CLR;
      end
      S_PR_CLR:  state_d = S_PR_STEP;
      S_PR_STEP: state_d = at_leaf ? S_PR_FREE : S_PR_RD;
      S_PR_RD:   state_d = S_PR_FREE;
      S_PR_FREE: state_d = at_leaf ? S_E_RELEASE : S_PR_STEP;
      S_E_RELEASE: state_d = S_DONE;
      S_Q_ID:    state_d = S_DONE;
      S_DONE:    if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and memory commands
  always_comb begin
    logic [NWW-1:0] w;
    w = '0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_item_d   = out_item_q;
    node_fh_d    = node_fh_q;
    ent_fh_d     = ent_fh_q;
    node_bump_d  = node_bump_q;
    ent_bump_d   = ent_bump_q;
    nodes_used_d = nodes_used_q;
    ents_used_d  = ents_used_q;
    req_d        = req_q;
    key_d        = key_q;
    id_d         = id_q;
    val_d        = val_q;
    status_d     = status_q;
    cur_d        = cur_q;
    nxt_d        = nxt_q;
    depth_d      = depth_q;
    missing_d    = missing_q;
    parent_d     = parent_q;
    pword_d      = pword_q;
    new_d        = new_q;
    leaf_d       = leaf_q;
    lword_d      = lword_q;
    ent_d        = ent_q;
    head_d       = head_q;
    br_node_d    = br_node_q;
    br_word_d    = br_word_q;
    br_depth_d   = br_depth_q;
    n_rd_en      = 1'b0;
    n_rd_addr    = cur_q;
    n_wr_en      = 1'b0;
    n_wr_addr    = cur_q;
    n_wr_data    = '0;
    e_rd_en      = 1'b0;
    e_rd_addr    = head_q;
    e_wr_en      = 1'b0;
    e_wr_addr    = ent_q;
    e_wr_data    = '0;

    case (state_q)
      // take the item and read the root
      S_IDLE: begin
        if (in_valid_i) begin
          req_d     = in_item_i.req_type;
          key_d     = in_item_i.key[KEY_BITS-1:0];
          id_d      = ID_BITS'(in_item_i.entry_id);
          val_d     = '0;
          status_d  = ST_OK;
          cur_d     = '0;
          depth_d   = '0;
          n_rd_en   = 1'b1;
          n_rd_addr = '0;
        end
      end
      // one trie level per cycle
      S_WALK: begin
        if (at_leaf) begin
          leaf_d    = cur_q;
          lword_d   = n_rd_data;
          missing_d = '0;
          head_d    = eidx(link0);
          e_rd_en   = (req_q == REQ_DELETE) || (req_q == REQ_QUERY);
          e_rd_addr = eidx(link0);
        end else begin
          case (req_q)
            REQ_INSERT: begin
              if (child == '0) begin
                missing_d = DW'(KEY_BITS) - depth_q;
                parent_d  = cur_q;
                pword_d   = n_rd_data;
              end else begin
                cur_d     = child;
                depth_d   = depth_q + 1'b1;
                n_rd_en   = 1'b1;
                n_rd_addr = child;
              end
            end
            REQ_DELETE: begin
              if (depth0 && root_empty) begin
                status_d = ST_EMPTY;
              end else if (child == '0) begin
                status_d = ST_ABSENT;
              end else begin
                // deepest node that keeps a sibling bounds the prune
                if (depth0 || link_nb != '0) begin
                  br_node_d  = cur_q;
                  br_word_d  = n_rd_data;
                  br_depth_d = depth_q;
                end
                cur_d     = child;
                depth_d   = depth_q + 1'b1;
                n_rd_en   = 1'b1;
                n_rd_addr = child;
              end
            end
            REQ_QUERY: begin
              if (depth0 && root_empty) begin
                status_d = ST_EMPTY;
              end else begin
                cur_d     = q_next;
                depth_d   = depth_q + 1'b1;
                n_rd_en   = 1'b1;
                n_rd_addr = q_next;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_CHK: begin
        if (full) status_d = ST_FULL;
      end
      // node allocation, free list first
      S_N_ALLOC: begin
        if (node_fh_q != '0) begin
          n_rd_en   = 1'b1;
          n_rd_addr = node_fh_q;
        end else begin
          new_d       = bump_node;
          node_bump_d = node_bump_q + 1'b1;
        end
      end
      S_N_FREE: begin
        new_d     = node_fh_q;
        node_fh_d = nidx(link0);
      end
      S_N_LINK: begin
        w = pword_q;
        w[bit_cur*LW +: LW] = LW'(new_q);
        n_wr_en      = 1'b1;
        n_wr_addr    = parent_q;
        n_wr_data    = w;
        nodes_used_d = nodes_used_q + 1'b1;
        parent_d     = new_q;
        pword_d      = '0;
        depth_d      = depth_q + 1'b1;
        missing_d    = missing_q - 1'b1;
        leaf_d       = new_q;
        lword_d      = '0;
      end
      // entry allocation and append
      S_E_ALLOC: begin
        if (ent_fh_q != '0) begin
          e_rd_en   = 1'b1;
          e_rd_addr = ent_fh_q;
        end else begin
          ent_d      = (32'(ent_bump_q) < ENTRY_COUNT) ? ent_bump_q[EAW-1:0] : '0;
          ent_bump_d = ent_bump_q + 1'b1;
        end
      end
      S_E_FREE: begin
        ent_d    = ent_fh_q;
        ent_fh_d = e_next;
      end
      S_E_WRITE: begin
        e_wr_en     = 1'b1;
        e_wr_addr   = ent_q;
        e_wr_data   = {id_q, EAW'(0)};
        ents_used_d = ents_used_q + 1'b1;
        e_rd_en     = (lword_q[LW-1:0] != '0);
        e_rd_addr   = eidx(lword_q[NWW-1:LW]);
      end
      S_E_TAIL: begin
        e_wr_en   = 1'b1;
        e_wr_addr = eidx(lword_q[NWW-1:LW]);
        e_wr_data = {e_id, ent_q};
      end
      S_L_WRITE: begin
        n_wr_en   = 1'b1;
        n_wr_addr = leaf_q;
        n_wr_data = {LW'(ent_q),
                     (lword_q[LW-1:0] == '0) ? LW'(ent_q) : lword_q[LW-1:0]};
      end
      // delete: pop the head id
      S_DEL_HEAD: begin
        val_d   = e_id;
        depth_d = br_depth_q;
        if (LW'(head_q) != lword_q[NWW-1:LW]) begin
          n_wr_en   = 1'b1;
          n_wr_addr = leaf_q;
          n_wr_data = {lword_q[NWW-1:LW], LW'(e_next)};
        end
      end
      // prune: cut the branch, then free the path below it
      S_PR_CLR: begin
        w = br_word_q;
        w[bit_cur*LW +: LW] = '0;
        n_wr_en   = 1'b1;
        n_wr_addr = br_node_q;
        n_wr_data = w;
        cur_d     = nidx(br_word_q[bit_cur*LW +: LW]);
        depth_d   = depth_q + 1'b1;
      end
      S_PR_STEP: begin
        n_rd_en   = !at_leaf;
        n_rd_addr = cur_q;
      end
      S_PR_RD: begin
        nxt_d = child;
      end
      S_PR_FREE: begin
        n_wr_en      = 1'b1;
        n_wr_addr    = cur_q;
        n_wr_data    = {LW'(0), LW'(node_fh_q)};
        node_fh_d    = cur_q;
        nodes_used_d = nodes_used_q - 1'b1;
        cur_d        = nxt_q;
        depth_d      = depth_q + 1'b1;
      end
      S_E_RELEASE: begin
        e_wr_en     = 1'b1;
        e_wr_addr   = head_q;
        e_wr_data   = {val_q, ent_fh_q};
        ent_fh_d    = head_q;
        ents_used_d = ents_used_q - 1'b1;
      end
      S_Q_ID: begin
        val_d = e_id;
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_item_d.status  = status_q;
          out_item_d.best_id = (status_q == ST_OK) ? 20'(val_q) : '0;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      node_fh_q    <= '0;
      ent_fh_q     <= '0;
      node_bump_q  <= NCW'(1);
      ent_bump_q   <= ECW'(1);
      nodes_used_q <= NCW'(1);
      ents_used_q  <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      node_fh_q    <= node_fh_d;
      ent_fh_q     <= ent_fh_d;
      node_bump_q  <= node_bump_d;
      ent_bump_q   <= ent_bump_d;
      nodes_used_q <= nodes_used_d;
      ents_used_q  <= ents_used_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    req_q      <= req_d;
    key_q      <= key_d;
    id_q       <= id_d;
    val_q      <= val_d;
    status_q   <= status_d;
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
    depth_q    <= depth_d;
    missing_q  <= missing_d;
    parent_q   <= parent_d;
    pword_q    <= pword_d;
    new_q      <= new_d;
    leaf_q     <= leaf_d;
    lword_q    <= lword_d;
    ent_q      <= ent_d;
    head_q     <= head_d;
    br_node_q  <= br_node_d;
    br_word_q  <= br_word_d;
    br_depth_q <= br_depth_d;
  end

endmodule

/* rtl/core/btmx_node_mem.sv */
// ----------------------------------------------------------------------------
// btmx_node_mem
// Trie node store: two links per node (children, or a leaf's id FIFO head
// and tail), registered read. The root reads as zero until it is first written.
// ----------------------------------------------------------------------------
module btmx_node_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_o_unused_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic             zero_q;
  logic             root_ok_q;

  // root valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ok_q <= 1'b0;
      zero_q    <= 1'b0;
    end else begin
      if (wr_en_i && (wr_addr_i == '0)) root_ok_q <= 1'b1;
      if (rd_en_i) zero_q <= (rd_addr_i == '0) && !root_ok_q;
    end
  end

  // array write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_o_unused_i;
    if (rd_en_i) rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = zero_q ? '0 : rd_q;

endmodule

/* rtl/core/btmx_entry_mem.sv */
// ----------------------------------------------------------------------------
// btmx_entry_mem
// FIFO entry store: id and next link per entry, registered read.
// ----------------------------------------------------------------------------
module btmx_entry_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int WIDTH = 36
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_o <= mem[rd_addr_i];
  end

endmodule

/* verif/binary_trie_max_xor_multiset_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor_multiset_test
// Self-checking bench for the trie max-xor multiset. A behavioral copy of the
// trie (nodes, id FIFOs, free lists) predicts status and id of every item;
// a queue-fed driver and a clocked monitor move items with random gaps.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_multiset_test;
  import btmx_pkg::*;

  localparam int KB    = 64;
  localparam int NODES = 65536;
  localparam int ENTS  = 65536;

  // request code with no operation behind it
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  binary_trie_max_xor_multiset DUT (.*);

  always #5 clk_i = ~clk_i;

  // Shadow trie; root is node 0, allocation starts one past it
  int unsigned kid0 [int unsigned];
  int unsigned kid1 [int unsigned];
  int unsigned ent_id [int unsigned];
  int unsigned ent_nx [int unsigned];
  int unsigned nfree = 0, efree = 0, nbump = 1, ebump = 1, n_used = 1, e_used = 0;
  int unsigned walk [KB+1];

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  logic [63:0] live_keys [$];
  int  errors, mismatches, n_ins, n_del, n_qry, n_full, n_absent, n_empty;
  bit  hold_go, hold_on;

  function automatic int unsigned kid(int unsigned n, bit b);
    if (b) return kid1.exists(n) ? kid1[n] : 0;
    return kid0.exists(n) ? kid0[n] : 0;
  endfunction

  function automatic void set_kid(int unsigned n, bit b, int unsigned v);
    if (b) kid1[n] = v; else kid0[n] = v;
  endfunction

  function automatic int unsigned grab_node();
    int unsigned n;
    if (nfree != 0) begin
      n = nfree;
      nfree = kid(n, 0);
    end else begin
      n = nbump;
      nbump++;
    end
    kid0[n] = 0;
    kid1[n] = 0;
    n_used++;
    return n;
  endfunction

  function automatic void drop_node(int unsigned n);
    kid0[n] = nfree;
    kid1[n] = 0;
    nfree = n;
    n_used--;
  endfunction

  function automatic bit kbit(logic [63:0] k, int d);
    return k[KB-1-d];
  endfunction

  // Expected response of the multiset to one item; updates the shadow trie
  function automatic out_item_t trie_apply(in_item_t it);
    out_item_t r;
    int unsigned cur, missing, e, leaf, head, n, want;
    bit b;
    r = '0;
    cur = 0;
    case (it.req_type)
      REQ_INSERT: begin
        missing = 0;
        for (int d = 0; d < KB; d++) begin
          cur = kid(cur, kbit(it.key, d));
          if (cur == 0) begin
            missing = KB - d;
            break;
          end
        end
        if (missing > NODES - n_used || e_used >= ENTS - 1) begin
          r.status = ST_FULL;
        end else begin
          cur = 0;
          for (int d = 0; d < KB; d++) begin
            b = kbit(it.key, d);
            if (kid(cur, b) == 0) set_kid(cur, b, grab_node());
            cur = kid(cur, b);
          end
          leaf = cur;
          if (efree != 0) begin
            e = efree;
            efree = ent_nx[e];
          end else begin
            e = ebump;
            ebump++;
          end
          e_used++;
          ent_id[e] = 32'(it.entry_id);
          ent_nx[e] = 0;
          if (kid(leaf, 0) == 0) kid0[leaf] = e;
          else ent_nx[kid(leaf, 1)] = e;
          kid1[leaf] = e;
          r.status = ST_OK;
        end
      end
      REQ_DELETE: begin
        if (kid(0, 0) == 0 && kid(0, 1) == 0) begin
          r.status = ST_EMPTY;
        end else begin
          walk[0] = 0;
          r.status = ST_OK;
          for (int d = 0; d < KB; d++) begin
            cur = kid(cur, kbit(it.key, d));
            if (cur == 0) begin
              r.status = ST_ABSENT;
              break;
            end
            walk[d+1] = cur;
          end
          if (r.status == ST_OK) begin
            leaf = cur;
            head = kid(leaf, 0);
            r.best_id = 20'(ent_id[head]);
            if (head != kid(leaf, 1)) begin
              kid0[leaf] = ent_nx[head];
            end else begin
              drop_node(leaf);
              for (int d = KB - 1; d >= 0; d--) begin
                n = walk[d];
                b = kbit(it.key, d);
                set_kid(n, b, 0);
                if (kid(n, !b) != 0 || d == 0) break;
                drop_node(n);
              end
            end
            ent_nx[head] = efree;
            efree = head;
            e_used--;
          end
        end
      end
      REQ_QUERY: begin
        if (kid(0, 0) == 0 && kid(0, 1) == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int d = 0; d < KB; d++) begin
            b = kbit(it.key, d);
            want = kid(cur, !b);
            cur = (want != 0) ? want : kid(cur, b);
          end
          r.status = ST_OK;
          r.best_id = 20'(ent_id[kid(cur, 0)]);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t mk(logic [1:0] op, logic [63:0] k, logic [19:0] id);
    in_item_t it;
    it.req_type = op;
    it.key = k;
    it.entry_id = id;
    return it;
  endfunction

  // Random item; insert and delete keys are biased toward keys inserted before
  function automatic in_item_t rand_item();
    int unsigned sel;
    logic [63:0] k;
    sel = $urandom_range(0, 99);
    if (live_keys.size() > 0 && $urandom_range(0, 2) != 0)
      k = live_keys[$urandom_range(0, live_keys.size() - 1)];
    else if ($urandom_range(0, 3) == 0)
      k = {4'($urandom_range(0, 15)), 60'h0};
    else
      k = rand_key();
    if ($urandom_range(0, 9) == 0) k[0] = ~k[0];
    if (sel < 45) begin
      if (live_keys.size() < 200) live_keys.push_back(k);
      return mk(REQ_INSERT, k, 20'($urandom));
    end
    if (sel < 75) return mk(REQ_DELETE, k, 20'($urandom));
    if (sel < 97) return mk(REQ_QUERY, rand_key(), 20'($urandom));
    return mk(REQ_UNUSED, k, 20'($urandom));
  endfunction

  // Driver: random gap between items, holds payload while stalled
  int gap_left;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(trie_apply(in_item_i));
        case (in_item_i.req_type)
          REQ_INSERT: n_ins++;
          REQ_DELETE: n_del++;
          REQ_QUERY:  n_qry++;
          default: ;
        endcase
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted here; the monitor turns it into stall
  initial begin
    wait (hold_go);
    hold_on = 1'b1;
    repeat (2000) @(posedge clk_i);
    hold_on = 1'b0;
  end

  // Monitor: compares each result with the oldest expectation
  int stall_left;
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %p", out_item_o);
        end else begin
          exp_r = expected_results.pop_front();
          case (exp_r.status)
            ST_FULL:   n_full++;
            ST_ABSENT: n_absent++;
            ST_EMPTY:  n_empty++;
            default: ;
          endcase
          if (exp_r.status !== out_item_o.status || exp_r.best_id !== out_item_o.best_id)
          begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp status %0d id %0h, got status %0d id %0h",
                       exp_r.status, exp_r.best_id, out_item_o.status, out_item_o.best_id);
          end
        end
      end
      if (hold_on) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
      end
    end
  end

  // wait until everything sent has been answered; sample after the edge settles
  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty set, absent key, unused code, extremes, duplicates, pruning
    pending_items.push_back(mk(REQ_QUERY, 64'h0, 20'h0));
    pending_items.push_back(mk(REQ_DELETE, 64'h0, 20'h0));
    pending_items.push_back(mk(REQ_UNUSED, '1, '1));
    pending_items.push_back(mk(REQ_INSERT, 64'h0, 20'hFFFFF));
    pending_items.push_back(mk(REQ_INSERT, '1, 20'h00001));
    pending_items.push_back(mk(REQ_INSERT, 64'h0, 20'h12345));
    pending_items.push_back(mk(REQ_QUERY, 64'h0, 20'h0));
    pending_items.push_back(mk(REQ_QUERY, '1, 20'h0));
    pending_items.push_back(mk(REQ_DELETE, 64'h5, 20'h0));
    pending_items.push_back(mk(REQ_DELETE, 64'h0, 20'h0));
    pending_items.push_back(mk(REQ_QUERY, '1, 20'h0));
    pending_items.push_back(mk(REQ_INSERT, 64'h1, 20'hABCDE));
    pending_items.push_back(mk(REQ_DELETE, 64'h0, 20'h0));
    pending_items.push_back(mk(REQ_QUERY, 64'h8000_0000_0000_0000, 20'h0));
    pending_items.push_back(mk(REQ_DELETE, 64'h1, 20'h0));
    pending_items.push_back(mk(REQ_DELETE, '1, 20'h0));
    pending_items.push_back(mk(REQ_DELETE, '1, 20'h0));
    pending_items.push_back(mk(REQ_QUERY, 64'h1234, 20'h0));
    drain();

    // Receiver holds off while the sender keeps offering
    for (int i = 0; i < 20; i++) pending_items.push_back(rand_item());
    hold_go = 1'b1;
    drain();

    for (int i = 0; i < 1400; i++) begin
      pending_items.push_back(rand_item());
      if (i == 700) drain();
      while (pending_items.size() > 30) @(posedge clk_i);
    end
    drain();

    $display("ran %0d inserts, %0d deletes, %0d queries", n_ins, n_del, n_qry);
    $display("statuses seen: %0d empty, %0d absent, %0d full", n_empty, n_absent, n_full);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/btmx_pkg.sv
rtl/core/btmx_node_mem.sv
rtl/core/btmx_entry_mem.sv
rtl/core/binary_trie_max_xor_multiset.sv
verif/binary_trie_max_xor_multiset_test.sv
